// ----- rtl/ddps_pkg.sv -----
// Shared widths, defaults and register codes for the device patrol scheduler.
package ddps_pkg;

  localparam int TIME_W          = 32;
  localparam int CNT_W           = 5;
  localparam int IVL_W           = 16;
  localparam int IDX_W           = 4;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int MAX_DEVICES_DEF = 16;
  localparam int MIN_INTERVAL    = 3;
  localparam int MIN_WAIT        = 3;
  localparam int MIN_POOL        = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ROTATE_MODE  = 2'd0,
    CFG_DEVICE_COUNT = 2'd1,
    CFG_INTERVAL     = 2'd2,
    CFG_POOL_SIZE    = 2'd3
  } cfg_reg_t;

endpackage

// ----- rtl/ddps_if.sv -----
// Handshake channels for scheduler ticks and visit selections.
interface ddps_in_if;
  logic                        valid;
  logic                        ready;
  logic [ddps_pkg::TIME_W-1:0] now_seconds;

  modport source (output valid, output now_seconds, input ready);
  modport sink (input valid, input now_seconds, output ready);
endinterface

interface ddps_out_if;
  logic                       valid;
  logic                       ready;
  logic [ddps_pkg::IDX_W-1:0] device_index;
  logic                       last_of_run;

  modport source (output valid, output device_index, output last_of_run, input ready);
  modport sink (input valid, input device_index, input last_of_run, output ready);
endinterface

// ----- rtl/due_device_patrol_scheduler.sv -----
// Device patrol scheduler: picks the devices to visit on each time tick.
//
// Each tick transaction carries the time in seconds and yields a run of device
// indices, the final one flagged by last_of_run. In rotate mode a silent tick
// only counts down the wait; on an emitting tick one shared restoring divider runs
// 16 steps for the gap (interval / count) and another 16 for the round-robin
// position modulo the count. In pool mode each device scanned needs a read and
// a check, because the visit-time memory has one registered read port; a
// stalled result port adds its wait. The block takes no tick until the previous
// run is handed to the output register. Visit times reset to never-visited
// through a valid bit per device, so no clearing pass follows reset.
module due_device_patrol_scheduler #(
  parameter int MAX_DEVICES = ddps_pkg::MAX_DEVICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ddps_in_if.sink                         in_chan,
  ddps_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [ddps_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [ddps_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CW     = (ADDR_W > ddps_pkg::CNT_W) ? ADDR_W : ddps_pkg::CNT_W;
  localparam int TW     = ddps_pkg::TIME_W;
  localparam int NW     = ddps_pkg::CNT_W;
  localparam int VW     = ddps_pkg::IVL_W;
  localparam int IW     = ddps_pkg::IDX_W;
  localparam int SW     = $clog2(VW);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_EMIT, S_RD, S_CHK} state_t;

  state_t          state_r, state_nxt;
  logic [TW-1:0]   now_r, now_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic [IW-1:0]   pend_r, pend_nxt;
  logic            has_pend_r, has_pend_nxt;
  logic [NW-1:0]   rem_r, rem_nxt;
  logic [VW-1:0]   quo_r, quo_nxt;
  logic [SW-1:0]   step_r, step_nxt;
  logic            div_pos_r, div_pos_nxt;
  logic [VW-1:0]   gap_r, gap_nxt;
  logic [NW-1:0]   rot_pos_r, rot_pos_nxt;
  logic [VW-1:0]   rot_wait_r, rot_wait_nxt;
  logic            mode_r, mode_nxt;
  logic [NW-1:0]   dev_cnt_r, dev_cnt_nxt;
  logic [VW-1:0]   ivl_r, ivl_nxt;
  logic [NW-1:0]   pool_r, pool_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [IW-1:0]   out_idx_r, out_idx_nxt;
  logic            out_last_r, out_last_nxt;
  logic            vld_r [MAX_DEVICES];

  // Visit-time memory with a registered read port
  logic [TW-1:0]   mem [MAX_DEVICES];
  logic [TW-1:0]   rd_stamp_r;
  logic            rd_vld_r;
  logic            mem_we;
  logic [ADDR_W-1:0] addr;

  logic [NW-1:0]   n;
  logic [VW-1:0]   base;
  logic [NW-1:0]   limit;
  logic            slot_free;
  logic [NW:0]     trial;
  logic            div_ge;
  logic [NW-1:0]   div_rem;
  logic [VW-1:0]   div_quo;
  logic [TW-1:0]   age;
  logic            due;

  assign addr = scan_r[ADDR_W-1:0];

  // Derive the effective count, interval and pool limit
  always_comb begin
    n     = (32'(dev_cnt_r) > 32'(MAX_DEVICES)) ? NW'(MAX_DEVICES) : dev_cnt_r;
    base  = (ivl_r < VW'(ddps_pkg::MIN_INTERVAL)) ? VW'(ddps_pkg::MIN_INTERVAL) : ivl_r;
    limit = (pool_r < NW'(ddps_pkg::MIN_POOL)) ? NW'(ddps_pkg::MIN_POOL) : pool_r;
  end

  // Shared divider step: one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, quo_r[VW-1]};
    div_ge  = (trial >= {1'b0, n});
    div_rem = div_ge ? NW'(trial - {1'b0, n}) : trial[NW-1:0];
    div_quo = {quo_r[VW-2:0], div_ge};
  end

  // Due test on the stamp just read
  assign age = now_r - rd_stamp_r;
  assign due = !rd_vld_r || (rd_stamp_r == '0) || (age >= TW'(base));

  assign slot_free = !out_valid_r || out_chan.ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    scan_nxt      = scan_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    has_pend_nxt  = has_pend_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    div_pos_nxt   = div_pos_r;
    gap_nxt       = gap_r;
    rot_pos_nxt   = rot_pos_r;
    rot_wait_nxt  = rot_wait_r;
    mode_nxt      = mode_r;
    dev_cnt_nxt   = dev_cnt_r;
    ivl_nxt       = ivl_r;
    pool_nxt      = pool_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;

    // Take configuration writes
    if (cfg_we) begin
      case (cfg_index)
        ddps_pkg::CFG_ROTATE_MODE:  mode_nxt    = cfg_wdata[0];
        ddps_pkg::CFG_DEVICE_COUNT: dev_cnt_nxt = cfg_wdata[NW-1:0];
        ddps_pkg::CFG_INTERVAL:     ivl_nxt     = cfg_wdata[VW-1:0];
        ddps_pkg::CFG_POOL_SIZE:    pool_nxt    = cfg_wdata[NW-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          now_nxt = in_chan.now_seconds;
          if (n != '0) begin
            if (mode_r) begin
              if (rot_wait_r != '0) begin
                rot_wait_nxt = rot_wait_r - VW'(1);
              end else begin
                rem_nxt     = '0;
                quo_nxt     = base;
                step_nxt    = '0;
                div_pos_nxt = 1'b0;
                state_nxt   = S_DIV;
              end
            end else begin
              scan_nxt     = '0;
              cnt_nxt      = '0;
              has_pend_nxt = 1'b0;
              state_nxt    = S_RD;
            end
          end
        end
      end
      S_DIV: begin
        rem_nxt  = div_rem;
        quo_nxt  = div_quo;
        step_nxt = step_r + SW'(1);
        if (step_r == SW'(VW - 1)) begin
          if (!div_pos_r) begin
            // Gap done: start the position modulo the count
            gap_nxt     = (div_quo < VW'(ddps_pkg::MIN_WAIT)) ?
                          VW'(ddps_pkg::MIN_WAIT) : div_quo;
            rem_nxt     = '0;
            quo_nxt     = VW'(rot_pos_r);
            step_nxt    = '0;
            div_pos_nxt = 1'b1;
          end else begin
            rot_pos_nxt  = ((div_rem + NW'(1)) == n) ? '0 : div_rem + NW'(1);
            rot_wait_nxt = gap_r;
            pend_nxt     = div_rem[IW-1:0];
            state_nxt    = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = pend_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RD: begin
        if ((scan_r == CW'(n)) || (cnt_r == limit)) begin
          state_nxt = has_pend_r ? S_EMIT : S_IDLE;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!due) begin
          scan_nxt  = scan_r + CW'(1);
          state_nxt = S_RD;
        end else if (!has_pend_r || slot_free) begin
          // Release the previous selection and hold this one
          if (has_pend_r) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = pend_r;
            out_last_nxt  = 1'b0;
          end
          mem_we       = 1'b1;
          pend_nxt     = scan_r[IW-1:0];
          has_pend_nxt = 1'b1;
          cnt_nxt      = cnt_r + NW'(1);
          scan_nxt     = scan_r + CW'(1);
          state_nxt    = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, configuration and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b0;
      dev_cnt_r   <= NW'(1);
      ivl_r       <= VW'(ddps_pkg::MIN_INTERVAL);
      pool_r      <= NW'(1);
      rot_pos_r   <= '0;
      rot_wait_r  <= '0;
      out_valid_r <= 1'b0;
      has_pend_r  <= 1'b0;
      for (int i = 0; i < MAX_DEVICES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      dev_cnt_r   <= dev_cnt_nxt;
      ivl_r       <= ivl_nxt;
      pool_r      <= pool_nxt;
      rot_pos_r   <= rot_pos_nxt;
      rot_wait_r  <= rot_wait_nxt;
      out_valid_r <= out_valid_nxt;
      has_pend_r  <= has_pend_nxt;
      if (mem_we) begin
        vld_r[addr] <= 1'b1;
      end
    end
    now_r     <= now_nxt;
    scan_r    <= scan_nxt;
    cnt_r     <= cnt_nxt;
    pend_r    <= pend_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    step_r    <= step_nxt;
    div_pos_r <= div_pos_nxt;
    gap_r     <= gap_nxt;
    out_idx_r <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  // Write the tick time and read one stamp per scan step
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= now_r;
    end
    if (state_r == S_RD) begin
      rd_stamp_r <= mem[addr];
      rd_vld_r   <= vld_r[addr];
    end
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.device_index = out_idx_r;
  assign out_chan.last_of_run  = out_last_r;

endmodule

// ----- rtl/ddps_checker.sv -----
// Port-level checks for the device patrol scheduler, bound to its top level.
module ddps_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ddps_pkg::IDX_W-1:0] device_index,
  input logic                       last_of_run
);

  // Hold a stalled selection
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("selection dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(device_index) && $stable(last_of_run))
    else $error("selection changed while stalled");

  // An idle block only ever holds the final selection of a run
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> last_of_run)
    else $error("idle with an unfinished run");

  // A stalled non-final selection keeps the run going
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !last_of_run |=> !in_ready)
    else $error("tick taken in the middle of a run");

endmodule

bind due_device_patrol_scheduler ddps_checker u_ddps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .device_index (out_chan.device_index),
  .last_of_run  (out_chan.last_of_run)
);
